[rtl/core/ssup_pkg.sv]
// ----------------------------------------------------------------------------
// ssup_pkg: shared types and constants of the supply output supervisor
// Field widths, device limits, reciprocal constants for the divide-by-constant
// steps, operation and register codes, and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package ssup_pkg;

    // Device limits
    localparam int unsigned MAX_CURRENT_MA = 5000;
    localparam int unsigned MAX_TIME_S     = 359999;
    localparam int unsigned MS_PER_S       = 1000;

    // Field widths
    localparam int MV_W       = 16;
    localparam int MA_W       = 16;
    localparam int MS_W       = 16;
    localparam int PWR_W      = 32;
    localparam int TIME_W     = 19;
    localparam int REM_W      = 10;
    localparam int ENERGY_W   = 48;
    localparam int OP_W       = 2;

    // Derived datapath widths
    localparam int PMAX_W     = MV_W + $clog2(MAX_CURRENT_MA + 1);
    localparam int P5_W       = PWR_W + 3;
    localparam int TOTAL_W    = MS_W + 1;
    localparam int SECS_W     = 7;
    localparam int PROD_W     = PWR_W + SECS_W;
    localparam int ADD_W      = 28;

    // floor(total / 1000) as (total * SEC_RECIP) >> SEC_SHIFT, exact for total < 2^17
    localparam int SEC_SHIFT   = 27;
    localparam int SEC_RECIP_W = 18;
    localparam logic [SEC_RECIP_W-1:0] SEC_RECIP =
        SEC_RECIP_W'(((64'd1 << SEC_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));
    localparam int SEC_PROD_W  = TOTAL_W + SEC_RECIP_W;

    // floor(prod / 3600) as (prod * EN_RECIP) >> EN_SHIFT, exact for prod < 2^39
    localparam int EN_SHIFT    = 51;
    localparam int EN_RECIP_W  = 40;
    localparam logic [EN_RECIP_W-1:0] EN_RECIP =
        EN_RECIP_W'(((64'd1 << EN_SHIFT) + 64'd3599) / 64'd3600);
    localparam int RECIP_SPLIT = 20;
    localparam int PP_W        = PROD_W + RECIP_SPLIT;
    localparam int SUM_W       = PP_W + RECIP_SPLIT + 1;

    // Stream and configuration port widths
    localparam int IN_DATA_W    = 64;
    localparam int IN_USER_W    = OP_W;
    localparam int OUT_FIELDS_W = 6 + TIME_W + ENERGY_W + PWR_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    // Result bit positions
    localparam int OUT_ON_BIT   = 0;
    localparam int OUT_CV_BIT   = 1;
    localparam int OUT_CC_BIT   = 2;
    localparam int OUT_PP_BIT   = 3;
    localparam int OUT_TRIP_BIT = 4;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE  = 2'd0,
        OP_ENABLE  = 2'd1,
        OP_DISABLE = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SET_VOLTAGE  = 2'd0,
        CFG_SET_CURRENT  = 2'd1,
        CFG_POWER_LIMIT  = 2'd2,
        CFG_TIMER_PRESET = 2'd3
    } t_cfg_idx;

    // Step enables from controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic cmp;
        logic prod;
        logic rlo;
        logic rhi;
        logic sum;
        logic commit;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sample_on;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/core/supply_output_supervisor.sv]
// ----------------------------------------------------------------------------
// supply_output_supervisor: bench supply output supervisor
// Power, CV/CC mode, over-power warning and trip, countdown timer or run
// clock, and energy accumulation for one supply output.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the operation (sample, enable, disable, clear
//   energy); tdata carries the sample fields. Every accepted transfer gives
//   exactly one result transfer on the master stream with the state after it.
//   Configuration registers are written through the plain write port while
//   the block is idle; a write lands on the clock edge where i_cfg_we is high.
//   An enable, disable, clear or a sample with the output off goes from the
//   multiply step straight to commit; a sample with the output on passes all
//   steps of the sequencer that walks one shared datapath through its product,
//   compare, seconds-split and two partial products of the divide by 3600.
//   The result is registered in the output register when the item commits.
//   The output register decouples the two sides: the next item is taken while
//   a result still waits. When the receiver stalls, the next result holds in
//   the sequencer and input stays blocked until the register frees.
//   Synchronous reset clears configuration and supervisor state: output off,
//   flags clear, timer and energy zero, no result pending.
// ----------------------------------------------------------------------------
module supply_output_supervisor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: vout_mv[15:0], iout_ma[31:16], vout_ceiling_mv[47:32], elapsed_ms[63:48]
    input  logic [ssup_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [ssup_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: output_on[0], cv_mode[1], cc_mode[2], power_warning[3], power_trip[4],
    //        timer_running[5], timer_seconds[24:6], energy_uwh[72:25],
    //        power_uw[104:73], zero fill[111:105]
    output logic [ssup_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [ssup_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [ssup_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import ssup_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer: accept, step, commit when the output register is free
    ssup_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: configuration, supervisor state, arithmetic, output register
    ssup_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[rtl/core/ssup_ctrl.sv]
// ----------------------------------------------------------------------------
// ssup_ctrl: step sequencer of the supply output supervisor
// Accepts one item, walks the datapath through its steps and commits the
// result once the output register is free.
// ----------------------------------------------------------------------------
module ssup_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ssup_pkg::t_dp_sts i_sts,
    output ssup_pkg::t_dp_cmd o_cmd
);
    import ssup_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_PROD,
        ST_RLO,
        ST_RHI,
        ST_SUM,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    assign o_in_ready = r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= ST_MUL;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_MUL: begin
                    // only a sample with the output on needs the arithmetic steps
                    r_state <= i_sts.sample_on ? ST_CMP : ST_DONE;
                end
                ST_CMP:  r_state <= ST_PROD;
                ST_PROD: r_state <= ST_RLO;
                ST_RLO:  r_state <= ST_RHI;
                ST_RHI:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DONE;
                ST_DONE: begin
                    if (i_sts.out_free) begin
                        r_state    <= ST_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= ST_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.mul    = (r_state == ST_MUL);
        o_cmd.cmp    = (r_state == ST_CMP);
        o_cmd.prod   = (r_state == ST_PROD);
        o_cmd.rlo    = (r_state == ST_RLO);
        o_cmd.rhi    = (r_state == ST_RHI);
        o_cmd.sum    = (r_state == ST_SUM);
        o_cmd.commit = (r_state == ST_DONE) && i_sts.out_free;
    end

endmodule

[rtl/core/ssup_dpath.sv]
// ----------------------------------------------------------------------------
// ssup_dpath: datapath of the supply output supervisor
// Holds configuration, supervisor state, step intermediates and the output
// register; each step is enabled by the controller.
// ----------------------------------------------------------------------------
module ssup_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssup_pkg::t_dp_cmd                  i_cmd,
    output ssup_pkg::t_dp_sts                  o_sts,
    input  logic [ssup_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic [ssup_pkg::IN_USER_W-1:0]     i_in_user,
    input  logic                               i_cfg_we,
    input  logic [ssup_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ssup_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [ssup_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import ssup_pkg::*;

    // Configuration
    logic [MV_W-1:0]   r_set_v;
    logic [MA_W-1:0]   r_set_i;
    logic [PWR_W-1:0]  r_limit;
    logic [TIME_W-1:0] r_preset;

    // Supervisor state
    logic                r_on, r_cv, r_cc, r_pp, r_opp, r_tm;
    logic [TIME_W-1:0]   r_timer;
    logic [REM_W-1:0]    r_rem;
    logic [ENERGY_W-1:0] r_energy;

    // Captured item
    t_op            r_op;
    logic           r_smp;
    logic [MV_W-1:0] r_v, r_ceil;
    logic [MA_W-1:0] r_i;
    logic [MS_W-1:0] r_el;

    // Intermediates
    logic [PWR_W-1:0]   r_p;
    logic [PMAX_W-1:0]  r_pmax;
    logic [TOTAL_W-1:0] r_total;
    logic               r_cc_sel, r_trip, r_warn;
    logic [SECS_W-1:0]  r_secs;
    logic [PROD_W-1:0]  r_prod;
    logic [REM_W-1:0]   r_rem_new;
    logic [PP_W-1:0]    r_pp_lo, r_pp_hi;
    logic [ADD_W-1:0]   r_add;

    // Output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Combinational helpers
    logic [MV_W-1:0]        vd;
    logic [MA_W-1:0]        id;
    logic [P5_W-1:0]        p5, lim4, pmax4;
    logic                   lim_on;
    logic [SEC_PROD_W-1:0]  sec_full;
    logic [SUM_W-1:0]       en_sum;
    logic [TIME_W-1:0]      preset_sat;
    logic [TIME_W:0]        clock_sum;
    logic [ENERGY_W:0]      energy_sum;
    logic                   out_free;

    logic                   n_on, n_cv, n_cc, n_pp, n_opp, n_tm;
    logic [TIME_W-1:0]      n_timer;
    logic [REM_W-1:0]       n_rem;
    logic [ENERGY_W-1:0]    n_energy;
    logic [PWR_W-1:0]       n_power;

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_sts.out_free  = out_free;
    assign o_sts.sample_on = r_smp;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;

    assign vd = (r_set_v > r_v) ? (r_set_v - r_v) : (r_v - r_set_v);
    assign id = (r_set_i > r_i) ? (r_set_i - r_i) : (r_i - r_set_i);

    assign lim_on   = (r_limit != '0);
    assign p5       = {r_p, 2'b00} + P5_W'(r_p);
    assign lim4     = P5_W'({r_limit, 2'b00});
    assign pmax4    = P5_W'({r_pmax, 2'b00});
    assign sec_full = SEC_PROD_W'(r_total) * SEC_PROD_W'(SEC_RECIP);
    assign en_sum   = {1'b0, r_pp_hi, {RECIP_SPLIT{1'b0}}} + SUM_W'(r_pp_lo);

    assign preset_sat = (r_preset > TIME_W'(MAX_TIME_S)) ? TIME_W'(MAX_TIME_S) : r_preset;
    assign clock_sum  = {1'b0, r_timer} + (TIME_W + 1)'(r_secs);
    assign energy_sum = {1'b0, r_energy} + (ENERGY_W + 1)'(r_add);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_v  <= '0;
            r_set_i  <= '0;
            r_limit  <= '0;
            r_preset <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SET_VOLTAGE:  r_set_v  <= i_cfg_wdata[MV_W-1:0];
                CFG_SET_CURRENT:  r_set_i  <= i_cfg_wdata[MA_W-1:0];
                CFG_POWER_LIMIT:  r_limit  <= i_cfg_wdata[PWR_W-1:0];
                CFG_TIMER_PRESET: r_preset <= i_cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_in_user);
            r_smp  <= (t_op'(i_in_user) == OP_SAMPLE) && r_on;
            r_v    <= i_in_data[15:0];
            r_i    <= i_in_data[31:16];
            r_ceil <= i_in_data[47:32];
            r_el   <= i_in_data[63:48];
        end
        if (i_cmd.mul) begin
            r_p      <= PWR_W'(r_v) * PWR_W'(r_i);
            r_pmax   <= PMAX_W'(r_ceil) * PMAX_W'(MAX_CURRENT_MA);
            r_total  <= TOTAL_W'(r_rem) + TOTAL_W'(r_el);
            r_cc_sel <= (id < vd);
        end
        if (i_cmd.cmp) begin
            r_trip <= (lim_on && (r_p >= r_limit)) || (r_p >= PWR_W'(r_pmax));
            r_warn <= (lim_on && (p5 >= lim4)) || (p5 >= pmax4);
            r_secs <= sec_full[SEC_SHIFT +: SECS_W];
        end
        if (i_cmd.prod) begin
            r_prod    <= PROD_W'(r_p) * PROD_W'(r_secs);
            r_rem_new <= REM_W'(r_total - TOTAL_W'(r_secs) * TOTAL_W'(MS_PER_S));
        end
        if (i_cmd.rlo) begin
            r_pp_lo <= PP_W'(r_prod) * PP_W'(EN_RECIP[RECIP_SPLIT-1:0]);
        end
        if (i_cmd.rhi) begin
            r_pp_hi <= PP_W'(r_prod) * PP_W'(EN_RECIP[EN_RECIP_W-1:RECIP_SPLIT]);
        end
        if (i_cmd.sum) begin
            r_add <= en_sum[EN_SHIFT +: ADD_W];
        end
    end

    // Next supervisor state for the committed item
    always_comb begin
        n_on     = r_on;
        n_cv     = r_cv;
        n_cc     = r_cc;
        n_pp     = r_pp;
        n_opp    = r_opp;
        n_tm     = r_tm;
        n_timer  = r_timer;
        n_rem    = r_rem;
        n_energy = r_energy;
        n_power  = '0;
        case (r_op)
            OP_SAMPLE: begin
                if (r_smp) begin
                    n_power = r_p;
                    n_cc    = r_cc_sel;
                    n_cv    = !r_cc_sel;
                    if (r_trip) begin
                        // latch the trip, switch off, reload the timer preset, skip energy
                        n_on    = 1'b0;
                        n_cv    = 1'b0;
                        n_cc    = 1'b0;
                        n_pp    = 1'b0;
                        n_opp   = 1'b1;
                        n_tm    = 1'b0;
                        n_timer = preset_sat;
                    end else begin
                        n_pp  = r_warn;
                        n_opp = 1'b0;
                        n_rem = r_rem_new;
                        if (r_secs != '0) begin
                            if (r_preset != '0) begin
                                n_timer = (r_timer > TIME_W'(r_secs)) ?
                                          (r_timer - TIME_W'(r_secs)) : '0;
                                n_tm    = 1'b1;
                            end else begin
                                n_timer = (clock_sum > (TIME_W + 1)'(MAX_TIME_S)) ?
                                          TIME_W'(MAX_TIME_S) : clock_sum[TIME_W-1:0];
                            end
                            n_energy = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
                        end
                        if ((r_preset != '0) && (n_timer == '0)) begin
                            // countdown expired: switch off
                            n_on    = 1'b0;
                            n_cv    = 1'b0;
                            n_cc    = 1'b0;
                            n_pp    = 1'b0;
                            n_tm    = 1'b0;
                            n_timer = preset_sat;
                        end
                    end
                end
            end
            OP_ENABLE: begin
                n_on    = 1'b1;
                n_cv    = 1'b0;
                n_cc    = 1'b0;
                n_pp    = 1'b0;
                n_opp   = 1'b0;
                n_tm    = 1'b0;
                n_rem   = '0;
                n_timer = (preset_sat != '0) ? (preset_sat - TIME_W'(1)) : '0;
            end
            OP_DISABLE: begin
                // the trip stays latched only when the output was on
                if (!r_on) begin
                    n_opp = 1'b0;
                end
                n_on    = 1'b0;
                n_cv    = 1'b0;
                n_cc    = 1'b0;
                n_pp    = 1'b0;
                n_tm    = 1'b0;
                n_timer = preset_sat;
            end
            OP_CLEAR: begin
                n_energy = '0;
            end
            default: ;
        endcase
    end

    // State and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on        <= 1'b0;
            r_cv        <= 1'b0;
            r_cc        <= 1'b0;
            r_pp        <= 1'b0;
            r_opp       <= 1'b0;
            r_tm        <= 1'b0;
            r_timer     <= '0;
            r_rem       <= '0;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_on        <= n_on;
                r_cv        <= n_cv;
                r_cc        <= n_cc;
                r_pp        <= n_pp;
                r_opp       <= n_opp;
                r_tm        <= n_tm;
                r_timer     <= n_timer;
                r_rem       <= n_rem;
                r_energy    <= n_energy;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= OUT_DATA_W'({n_power, n_energy, n_timer,
                                       n_tm, n_opp, n_pp, n_cc, n_cv, n_on});
        end
    end

endmodule

[rtl/core/ssup_checker.sv]
// ----------------------------------------------------------------------------
// ssup_checker: port-level checks of the supply output supervisor
// Tracks transfers in flight and checks reset, stalled-result stability, result count and flag consistency.
// ----------------------------------------------------------------------------
module ssup_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ssup_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import ssup_pkg::*;

    logic       in_xfer, out_xfer;
    logic [1:0] r_pend;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // items accepted whose result has not been transferred yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |-> r_pend != 2'd0)
        else $error("result without an accepted item");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> r_pend == 2'd0 || r_pend == 2'd1)
        else $error("item accepted with two results outstanding");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[OUT_CV_BIT] && m_axis_tdata[OUT_CC_BIT])
                       && !(m_axis_tdata[OUT_TRIP_BIT] && m_axis_tdata[OUT_ON_BIT]))
        else $error("inconsistent mode or trip flags");

endmodule

bind supply_output_supervisor ssup_checker u_ssup_checker (.*);
